### sv/bfhc_pkg.sv
// Shared types and constants for the bit-flip hill climbing step core.
package bfhc_pkg;

  localparam int MAX_DIMS_DEFAULT = 16;

  localparam int DIM_W    = 4;
  localparam int BIT_W    = 4;
  localparam int CODE_W   = 16;
  localparam int SUM_W    = 36;
  localparam int SQ_W     = 32;
  localparam int CREDIT_W = 16;
  localparam int DIMS_W   = 5;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 72;

  localparam logic [CODE_W-1:0]   CODE_MAX     = 16'hFFFF;
  // (2*65535 - 65535)^2, the squared offset of a code at its top value
  localparam logic [SQ_W-1:0]     SQ_MAX       = 32'd4294836225;
  localparam logic [DIMS_W-1:0]   RESET_DIMS   = 5'd2;
  localparam logic [CREDIT_W-1:0] RESET_BUDGET = 16'd10000;

  typedef enum logic [0:0] {
    REG_DIMS_IN_USE = 1'b0,
    REG_EVAL_BUDGET = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                en;
    cfg_reg_e            index;
    logic [CREDIT_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic              spend;
    logic              store;
    logic [DIM_W-1:0]  dim;
    logic [CODE_W-1:0] code;
    logic [SUM_W-1:0]  sum;
  } upd_t;

  typedef struct packed {
    logic              improve;
    logic [CODE_W-1:0] new_code;
    logic [SUM_W-1:0]  new_sum;
  } score_t;

endpackage

### sv/bfhc_score.sv
// Neighbor scoring: flip one bit, square both offsets, compare and form the new sum.
module bfhc_score (
  input  logic [bfhc_pkg::CODE_W-1:0] old_code,
  input  logic [bfhc_pkg::BIT_W-1:0]  flip_bit,
  input  logic [bfhc_pkg::SUM_W-1:0]  cur_sum,
  output bfhc_pkg::score_t            score
);
  import bfhc_pkg::*;

  logic [CODE_W-1:0] new_code;
  logic [CODE_W-1:0] abs_old;
  logic [CODE_W-1:0] abs_new;
  logic [SQ_W-1:0]   sq_old;
  logic [SQ_W-1:0]   sq_new;

  // |2c - 65535|: odd offset whose magnitude comes straight from the low bits
  function automatic logic [CODE_W-1:0] abs_offset(input logic [CODE_W-1:0] c);
    return c[CODE_W-1] ? {c[CODE_W-2:0], 1'b1} : ~{c[CODE_W-2:0], 1'b0};
  endfunction

  always_comb begin
    new_code = old_code ^ (CODE_W'(1) << flip_bit);
    abs_old  = abs_offset(old_code);
    abs_new  = abs_offset(new_code);
    sq_old   = abs_old * abs_old;
    sq_new   = abs_new * abs_new;
    score.improve  = abs_new < abs_old;
    score.new_code = new_code;
    score.new_sum  = cur_sum - SUM_W'(sq_old) + SUM_W'(sq_new);
  end

endmodule

### sv/bfhc_state.sv
// Search state: config registers, point codes, running sum and credit counter.
module bfhc_state #(
  parameter int MAX_DIMS = bfhc_pkg::MAX_DIMS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bfhc_pkg::cfg_wr_t             cfg_wr,
  input  bfhc_pkg::upd_t                upd,
  input  logic [bfhc_pkg::DIM_W-1:0]    rd_dim,
  output logic [bfhc_pkg::CODE_W-1:0]   rd_code,
  output logic [bfhc_pkg::DIMS_W-1:0]   active,
  output logic [bfhc_pkg::SUM_W-1:0]    cur_sum,
  output logic [bfhc_pkg::CREDIT_W-1:0] credits
);
  import bfhc_pkg::*;

  // Only dims below 2**DIM_W are reachable, so storage stops there.
  localparam int STORE_DEPTH = (MAX_DIMS < (1 << DIM_W)) ? MAX_DIMS : (1 << DIM_W);
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int DIMS_CAP    = (MAX_DIMS < (1 << DIMS_W) - 1) ? MAX_DIMS
                                                              : (1 << DIMS_W) - 1;

  logic [DIMS_W-1:0]   dims_in_use;
  logic [CREDIT_W-1:0] eval_budget;
  logic [CODE_W-1:0]   codes [STORE_DEPTH];

  logic [DIMS_W-1:0]   dims_next;
  logic [CREDIT_W-1:0] budget_next;
  logic [DIMS_W-1:0]   active_next;
  logic [SUM_W-1:0]    restart_sum;
  logic [CREDIT_W-1:0] restart_credits;

  function automatic logic [DIMS_W-1:0] cap_dims(input logic [DIMS_W-1:0] d);
    return (d > DIMS_W'(DIMS_CAP)) ? DIMS_W'(DIMS_CAP) : d;
  endfunction

  always_comb begin
    dims_next   = dims_in_use;
    budget_next = eval_budget;
    if (cfg_wr.index == REG_DIMS_IN_USE) begin
      dims_next = cfg_wr.data[DIMS_W-1:0];
    end else begin
      budget_next = cfg_wr.data;
    end
    active_next     = cap_dims(dims_next);
    restart_sum     = SUM_W'(active_next) * SUM_W'(SQ_MAX);
    restart_credits = (budget_next == '0) ? '0 : budget_next - CREDIT_W'(1);
  end

  assign active  = cap_dims(dims_in_use);
  assign rd_code = ({1'b0, rd_dim} < (DIM_W + 1)'(STORE_DEPTH)) ? codes[rd_dim[IDX_W-1:0]]
                                                                : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= RESET_DIMS;
      eval_budget <= RESET_BUDGET;
      cur_sum     <= SUM_W'(cap_dims(RESET_DIMS)) * SUM_W'(SQ_MAX);
      credits     <= RESET_BUDGET - CREDIT_W'(1);
      for (int i = 0; i < STORE_DEPTH; i++) codes[i] <= CODE_MAX;
    end else if (cfg_wr.en) begin
      dims_in_use <= dims_next;
      eval_budget <= budget_next;
      cur_sum     <= restart_sum;
      credits     <= restart_credits;
      for (int i = 0; i < STORE_DEPTH; i++) codes[i] <= CODE_MAX;
    end else begin
      if (upd.spend) credits <= credits - CREDIT_W'(1);
      if (upd.store) begin
        cur_sum <= upd.sum;
        codes[upd.dim[IDX_W-1:0]] <= upd.code;
      end
    end
  end

endmodule

### sv/bit_flip_hill_climb_step_core.sv
// Pipeline: input register, then result register.
// Throughput: one item per cycle while m_axis_tready does not hold the result register; the
// scoring of an item is a single pass of one 16x16 squaring pair, a compare and a 36-bit add.
// Reset: synchronous rst sets dims_in_use=2, eval_budget=10000, all codes to 65535,
// the sum to 2*65535^2 and 9999 credits; a config write restarts the search likewise.
// Both ready outputs stay low while rst is high.
module bit_flip_hill_climb_step_core #(
  parameter int MAX_DIMS = bfhc_pkg::MAX_DIMS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [3:0] flip_dim, [7:4] flip_bit
  input  logic [bfhc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] accepted, [36:1] best_sum, [52:37] new_code, [68:53] credits_left,
  // [69] budget_done, [70] bad_dim, [71] zero
  output logic [bfhc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [bfhc_pkg::CREDIT_W-1:0]   cfg_data
);
  import bfhc_pkg::*;

  // Input register stage
  logic              in_vld;
  logic [DIM_W-1:0]  in_dim;
  logic [BIT_W-1:0]  in_bit;

  // Result register
  logic                out_vld;
  logic                out_accepted;
  logic [SUM_W-1:0]    out_sum;
  logic [CODE_W-1:0]   out_code;
  logic [CREDIT_W-1:0] out_credits;
  logic                out_done;
  logic                out_bad;

  logic                advance;
  logic                fire;

  cfg_wr_t             cfg_wr;
  upd_t                upd;
  score_t              score;

  logic [CODE_W-1:0]   stored_code;
  logic [DIMS_W-1:0]   active;
  logic [SUM_W-1:0]    cur_sum;
  logic [CREDIT_W-1:0] credits;

  logic                bad;
  logic                work;
  logic                take;
  logic [CREDIT_W-1:0] credits_after;

  // The result register frees when empty or when its transaction goes out.
  assign advance       = !out_vld || m_axis_tready;
  assign fire          = in_vld && advance;
  assign s_axis_tready = !rst && (!in_vld || advance);
  assign cfg_ready     = !rst;

  assign cfg_wr.en    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_reg_e'(cfg_index);
  assign cfg_wr.data  = cfg_data;

  bfhc_state #(
    .MAX_DIMS(MAX_DIMS)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .cfg_wr  (cfg_wr),
    .upd     (upd),
    .rd_dim  (in_dim),
    .rd_code (stored_code),
    .active  (active),
    .cur_sum (cur_sum),
    .credits (credits)
  );

  bfhc_score u_score (
    .old_code (stored_code),
    .flip_bit (in_bit),
    .cur_sum  (cur_sum),
    .score    (score)
  );

  // A bad dim or an empty budget leaves everything untouched; otherwise spend
  // a credit and keep the neighbor only on strict improvement.
  always_comb begin
    bad           = {1'b0, in_dim} >= active;
    work          = !bad && (credits != '0);
    take          = work && score.improve;
    credits_after = work ? credits - CREDIT_W'(1) : credits;

    upd.spend = fire && work;
    upd.store = fire && take;
    upd.dim   = in_dim;
    upd.code  = score.new_code;
    upd.sum   = score.new_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld <= s_axis_tvalid;
      if (advance)       out_vld <= in_vld;
    end
  end

  // Payload registers: capture the input transaction, and the result on fire.
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_dim <= s_axis_tdata[DIM_W-1:0];
      in_bit <= s_axis_tdata[DIM_W+BIT_W-1:DIM_W];
    end
    if (fire) begin
      out_accepted <= take;
      out_sum      <= take ? score.new_sum : cur_sum;
      out_code     <= take ? score.new_code : stored_code;
      out_credits  <= credits_after;
      out_done     <= credits_after == '0;
      out_bad      <= bad;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {1'b0, out_bad, out_done, out_credits, out_code, out_sum,
                          out_accepted};

endmodule
